// ----- hw/rtl/solt_pkg.sv -----
// Shared types and constants of the socket owner lookup table.
`default_nettype none
package solt_pkg;

	localparam int TABLE_DEPTH_DEF = 512;
	localparam int PID_W           = 22;
	localparam int INDEX_W         = 9;
	localparam int PORT_W          = 16;
	localparam int PROTO_W         = 8;
	localparam int ADDR_W          = 64;
	localparam int REQ_W           = 2;

	localparam logic [REQ_W-1:0] REQ_INSERT  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_PUBLISH = 2'd1;
	localparam logic [REQ_W-1:0] REQ_LOOKUP  = 2'd2;

	// upper half of addr_lo for an ::ffff:a.b.c.d mapped entry
	localparam logic [31:0] MAPPED_TAG = 32'h0000_ffff;

	typedef struct packed {
		logic [ADDR_W-1:0]  addr_hi;
		logic [ADDR_W-1:0]  addr_lo;
		logic               is_ipv6;
		logic [PROTO_W-1:0] protocol;
		logic [PORT_W-1:0]  port;
		logic [PID_W-1:0]   owner;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_REPLY
	} ctrl_state_t;

	typedef struct packed {
		logic exec;       // transaction accepted: insert/publish now, lookup armed
		logic scan_step;  // advance the live bank scan
		logic out_load;   // move the result into the output register
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic out_free;
	} ctrl_status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/solt_ctrl.sv -----
// Controller state machine of the socket owner lookup table.
`default_nettype none
module solt_ctrl (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  wire [solt_pkg::REQ_W-1:0] req_type,
	input  solt_pkg::ctrl_status_t    status,
	output solt_pkg::ctrl_cmd_t       cmd
);
	import solt_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        accept;

	assign accept = in_valid && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (req_type == REQ_LOOKUP) ? ST_SCAN : ST_REPLY;
				end
			end
			ST_SCAN: begin
				if (status.scan_done) begin
					state_d = ST_REPLY;
				end
			end
			ST_REPLY: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		cmd.exec      = 1'b0;
		cmd.scan_step = 1'b0;
		cmd.out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.exec = accept;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			ST_REPLY: begin
				cmd.out_load = status.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- hw/rtl/solt_dp.sv -----
// Datapath: entry memory, bank counters, scan pipeline and output register.
`default_nettype none
module solt_dp #(
	parameter int TABLE_DEPTH = solt_pkg::TABLE_DEPTH_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  solt_pkg::ctrl_cmd_t         cmd,
	output solt_pkg::ctrl_status_t      status,
	input  wire [solt_pkg::REQ_W-1:0]   req_type,
	input  wire                         is_ipv6,
	input  wire [solt_pkg::PROTO_W-1:0] protocol,
	input  wire [solt_pkg::PORT_W-1:0]  port,
	input  wire [solt_pkg::ADDR_W-1:0]  addr_hi,
	input  wire [solt_pkg::ADDR_W-1:0]  addr_lo,
	input  wire [solt_pkg::PID_W-1:0]   owner_pid,
	output logic                        out_valid,
	input  wire                         out_ready,
	output logic                        found,
	output logic [solt_pkg::PID_W-1:0]  match_pid,
	output logic [solt_pkg::INDEX_W-1:0] match_index,
	output logic                        dropped
);
	import solt_pkg::*;

	localparam int STORE_DEPTH = 2 * TABLE_DEPTH;
	localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CW          = $clog2(TABLE_DEPTH + 1);

	entry_t mem [STORE_DEPTH];

	logic [CW-1:0] staging_count_q;
	logic [CW-1:0] live_count_q;
	logic          live_bank_q;

	// latched query
	logic                 q_ipv6_q;
	logic [PROTO_W-1:0]   q_proto_q;
	logic [PORT_W-1:0]    q_port_q;
	logic [ADDR_W-1:0]    q_hi_q;
	logic [ADDR_W-1:0]    q_lo_q;

	// scan pipeline
	logic [CW-1:0] scan_idx_q;
	logic          rd_valid_s1;
	logic [CW-1:0] rd_idx_s1;
	entry_t        rd_data_s1;
	logic          hit_q;

	// result waiting for the output register
	logic               res_found_q;
	logic [PID_W-1:0]   res_pid_q;
	logic [INDEX_W-1:0] res_index_q;
	logic               res_dropped_q;

	logic          is_insert;
	logic          is_publish;
	logic          staging_full;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_word;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          entry_hit;
	logic          more_entries;

	function automatic logic entry_match(
		input entry_t            e,
		input logic              fam,
		input logic [PROTO_W-1:0] proto,
		input logic [PORT_W-1:0] prt,
		input logic [ADDR_W-1:0] qhi,
		input logic [ADDR_W-1:0] qlo
	);
		logic key_ok;
		logic v4_eq;
		begin
			key_ok = (e.protocol == proto) && (e.port == prt);
			v4_eq  = (e.addr_lo[31:0] == qlo[31:0]);
			if (!key_ok) begin
				entry_match = 1'b0;
			end else if (e.is_ipv6 == fam) begin
				if (!fam) begin
					entry_match = v4_eq || (e.addr_lo[31:0] == 32'd0);
				end else begin
					entry_match = ((e.addr_hi == qhi) && (e.addr_lo == qlo)) ||
						((e.addr_hi == '0) && (e.addr_lo == '0));
				end
			end else if (!fam) begin
				// IPv4 query against an ::ffff: mapped IPv6 entry
				entry_match = (e.addr_hi == '0) && (e.addr_lo[63:32] == MAPPED_TAG) && v4_eq;
			end else begin
				entry_match = 1'b0;
			end
		end
	endfunction

	assign is_insert    = (req_type == REQ_INSERT);
	assign is_publish   = (req_type == REQ_PUBLISH);
	assign staging_full = (staging_count_q >= CW'(TABLE_DEPTH));

	// staging bank sits opposite the live bank
	assign wr_en   = cmd.exec && is_insert && !staging_full;
	assign wr_addr = AW'(staging_count_q) + (live_bank_q ? AW'(0) : AW'(TABLE_DEPTH));
	assign wr_word = '{addr_hi: addr_hi, addr_lo: addr_lo, is_ipv6: is_ipv6,
		protocol: protocol, port: port, owner: owner_pid};

	assign more_entries = (scan_idx_q < live_count_q);
	assign rd_en        = cmd.scan_step && !hit_q && more_entries;
	assign rd_addr      = AW'(scan_idx_q) + (live_bank_q ? AW'(TABLE_DEPTH) : AW'(0));

	assign entry_hit = rd_valid_s1 && !hit_q &&
		entry_match(rd_data_s1, q_ipv6_q, q_proto_q, q_port_q, q_hi_q, q_lo_q);

	assign status.scan_done = hit_q || (!rd_valid_s1 && !more_entries);
	assign status.out_free  = !out_valid || out_ready;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_word;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			staging_count_q <= '0;
			live_count_q    <= '0;
			live_bank_q     <= 1'b0;
		end else if (cmd.exec) begin
			if (wr_en) begin
				staging_count_q <= staging_count_q + CW'(1);
			end else if (is_publish) begin
				live_bank_q     <= ~live_bank_q;
				live_count_q    <= staging_count_q;
				staging_count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			q_ipv6_q  <= is_ipv6;
			q_proto_q <= protocol;
			q_port_q  <= port;
			q_hi_q    <= addr_hi;
			q_lo_q    <= addr_lo;
		end
		if (rd_en) begin
			rd_idx_s1 <= scan_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q  <= '0;
			rd_valid_s1 <= 1'b0;
			hit_q       <= 1'b0;
		end else if (cmd.exec) begin
			scan_idx_q  <= '0;
			rd_valid_s1 <= 1'b0;
			hit_q       <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
			if (rd_en) begin
				scan_idx_q <= scan_idx_q + CW'(1);
			end
			if (entry_hit) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_found_q   <= 1'b0;
			res_pid_q     <= '0;
			res_index_q   <= '0;
			res_dropped_q <= is_insert && staging_full;
		end else if (entry_hit) begin
			res_found_q <= 1'b1;
			res_pid_q   <= rd_data_s1.owner;
			res_index_q <= INDEX_W'(rd_idx_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			found       <= res_found_q;
			match_pid   <= res_pid_q;
			match_index <= res_index_q;
			dropped     <= res_dropped_q;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/socket_owner_lookup_table_core.sv -----
// Top level of the double-buffered socket owner lookup table.
`default_nettype none
//
// Channel   Direction  Handshake             Payload
// request   in         in_valid / in_ready   req_type is_ipv6 protocol port addr_hi
//                                            addr_lo owner_pid
// result    out        out_valid / out_ready found match_pid match_index dropped
//
// Insert and publish: the transaction is executed in its accept cycle, and the
// result goes to the output register from the reply state once it is free.
// Lookup: one live entry is read per cycle from the single read port of the
// entry memory and compared in the cycle after its read; the scan ends at the
// first hit or after the last live entry. The next request is accepted only
// once the current one has reached the output register.
// Reset clears state, valid flags, counts and bank select; the entry memory
// needs no clearing because only entries below the live count are ever read.
// A result waiting on out_ready does not block the next request from being
// accepted; only its completion waits for the output register to free up.
//
module socket_owner_lookup_table_core #(
	parameter int TABLE_DEPTH = solt_pkg::TABLE_DEPTH_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire [solt_pkg::REQ_W-1:0]    req_type,
	input  wire                          is_ipv6,
	input  wire [solt_pkg::PROTO_W-1:0]  protocol,
	input  wire [solt_pkg::PORT_W-1:0]   port,
	input  wire [solt_pkg::ADDR_W-1:0]   addr_hi,
	input  wire [solt_pkg::ADDR_W-1:0]   addr_lo,
	input  wire [solt_pkg::PID_W-1:0]    owner_pid,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic                         found,
	output logic [solt_pkg::PID_W-1:0]   match_pid,
	output logic [solt_pkg::INDEX_W-1:0] match_index,
	output logic                         dropped
);
	import solt_pkg::*;

	ctrl_cmd_t    cmd;
	ctrl_status_t status;

	// sequencing: accept, scan, reply
	solt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.status   (status),
		.cmd      (cmd)
	);

	// storage, compare and result registers
	solt_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.req_type    (req_type),
		.is_ipv6     (is_ipv6),
		.protocol    (protocol),
		.port        (port),
		.addr_hi     (addr_hi),
		.addr_lo     (addr_lo),
		.owner_pid   (owner_pid),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.match_pid   (match_pid),
		.match_index (match_index),
		.dropped     (dropped)
	);

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench of the socket owner lookup table core.
`timescale 1ns / 1ps

module testbench;
	import solt_pkg::*;

	localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;

	// request code that the block must answer without changing the table
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	localparam int RANDOM_ITEMS = 1170;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int MAX_GAP      = 12;
	localparam int STALL_LEN    = 300;
	localparam int STALL_AT_A   = 100;
	localparam int STALL_AT_B   = 700;

	// protocol and port kept out of the filler so the deep scans are exact
	localparam logic [PROTO_W-1:0] DEEP_PROTO = 8'd132;
	localparam logic [PORT_W-1:0]  DEEP_PORT  = 16'hbeef;

	localparam logic [31:0] V4_A = 32'h0a00_0001;
	localparam logic [31:0] V4_B = 32'hc0a8_0101;

	typedef struct {
		logic [REQ_W-1:0]   kind;
		logic               v6;
		logic [PROTO_W-1:0] proto;
		logic [PORT_W-1:0]  port;
		logic [ADDR_W-1:0]  hi;
		logic [ADDR_W-1:0]  lo;
		logic [PID_W-1:0]   pid;
		bit                 drain;  // hold this one back until all replies are in
	} sock_req_t;

	typedef struct {
		logic               found;
		logic [PID_W-1:0]   pid;
		logic [INDEX_W-1:0] index;
		logic               dropped;
	} owner_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [REQ_W-1:0]   req_type = '0;
	logic               is_ipv6 = 1'b0;
	logic [PROTO_W-1:0] protocol = '0;
	logic [PORT_W-1:0]  port = '0;
	logic [ADDR_W-1:0]  addr_hi = '0;
	logic [ADDR_W-1:0]  addr_lo = '0;
	logic [PID_W-1:0]   owner_pid = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               found;
	logic [PID_W-1:0]   match_pid;
	logic [INDEX_W-1:0] match_index;
	logic               dropped;

	socket_owner_lookup_table_core #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.is_ipv6    (is_ipv6),
		.protocol   (protocol),
		.port       (port),
		.addr_hi    (addr_hi),
		.addr_lo    (addr_lo),
		.owner_pid  (owner_pid),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.found      (found),
		.match_pid  (match_pid),
		.match_index(match_index),
		.dropped    (dropped)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	sock_req_t    req_backlog[$];   // requests waiting for the driver
	owner_reply_t replies_due[$];   // predicted replies, oldest first

	int  mismatches   = 0;
	int  results_seen = 0;
	int  queued_n     = 0;
	int  cycle_count  = 0;
	int  send_gap     = 0;
	int  recv_gap     = 0;
	bit  send_burst   = 1'b0;
	bit  recv_burst   = 1'b0;
	bit  in_fire      = 1'b0;
	bit  out_fire     = 1'b0;

	// ------------------------------------------------------------------
	// Table predictor: two banks in one flat store, live/staging selected
	// by a bank bit, same as the block keeps them.
	// ------------------------------------------------------------------
	entry_t        tbl_mem [2*TABLE_DEPTH];
	logic [9:0]    tbl_live_n   = '0;
	logic [9:0]    tbl_stage_n  = '0;
	logic          tbl_live_sel = 1'b0;

	function automatic entry_t to_entry(sock_req_t r);
		entry_t e;
		e.addr_hi  = r.hi;
		e.addr_lo  = r.lo;
		e.is_ipv6  = r.v6;
		e.protocol = r.proto;
		e.port     = r.port;
		e.owner    = r.pid;
		return e;
	endfunction

	function automatic owner_reply_t predict_reply(sock_req_t r);
		owner_reply_t rep;
		entry_t       e;
		bit           hit;
		int           live_base;
		int           stage_base;
		rep        = '{found: 1'b0, pid: '0, index: '0, dropped: 1'b0};
		live_base  = tbl_live_sel ? TABLE_DEPTH : 0;
		stage_base = tbl_live_sel ? 0 : TABLE_DEPTH;
		case (r.kind)
			REQ_INSERT: begin
				if (tbl_stage_n >= TABLE_DEPTH) begin
					rep.dropped = 1'b1;
				end else begin
					tbl_mem[stage_base + int'(tbl_stage_n)] = to_entry(r);
					tbl_stage_n = tbl_stage_n + 10'd1;
				end
			end
			REQ_PUBLISH: begin
				tbl_live_sel = ~tbl_live_sel;
				tbl_live_n   = tbl_stage_n;
				tbl_stage_n  = '0;
			end
			REQ_LOOKUP: begin
				// first match in insertion order wins
				for (int i = 0; i < int'(tbl_live_n); i++) begin
					e   = tbl_mem[live_base + i];
					hit = 1'b0;
					if (e.protocol == r.proto && e.port == r.port) begin
						if (e.is_ipv6 == r.v6) begin
							if (!r.v6)
								hit = e.addr_lo[31:0] == r.lo[31:0] || e.addr_lo[31:0] == 32'd0;
							else
								hit = (e.addr_hi == r.hi && e.addr_lo == r.lo) ||
								      (e.addr_hi == '0 && e.addr_lo == '0);
						end else if (!r.v6) begin
							// v4 query against an ::ffff:a.b.c.d entry
							hit = e.addr_hi == '0 && e.addr_lo[63:32] == MAPPED_TAG &&
							      e.addr_lo[31:0] == r.lo[31:0];
						end
					end
					if (hit) begin
						rep.found = 1'b1;
						rep.pid   = e.owner;
						rep.index = i[INDEX_W-1:0];
						break;
					end
				end
			end
			default: ;
		endcase
		return rep;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers. The generator keeps its own view of the staging and
	// live entries only to aim lookups at real keys.
	// ------------------------------------------------------------------
	entry_t gen_stage[$];
	entry_t gen_live[$];

	task automatic push_req(input logic [REQ_W-1:0] kind, input logic v6,
	                        input logic [PROTO_W-1:0] proto, input logic [PORT_W-1:0] prt,
	                        input logic [ADDR_W-1:0] hi, input logic [ADDR_W-1:0] lo,
	                        input logic [PID_W-1:0] pid, input bit drain);
		sock_req_t r;
		r = '{kind: kind, v6: v6, proto: proto, port: prt, hi: hi, lo: lo, pid: pid,
		      drain: drain};
		req_backlog.push_back(r);
		queued_n++;
		if (kind == REQ_INSERT && gen_stage.size() < TABLE_DEPTH) begin
			gen_stage.push_back(to_entry(r));
		end else if (kind == REQ_PUBLISH) begin
			gen_live = gen_stage;
			gen_stage.delete();
		end
	endtask

	function automatic int next_gap(bit burst);
		return burst ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	function automatic logic [PROTO_W-1:0] pick_proto();
		logic [PROTO_W-1:0] p;
		if ($urandom_range(0, 7) == 0)
			p = 8'($urandom);
		else
			p = $urandom_range(0, 1) ? 8'd6 : 8'd17;
		if (p == DEEP_PROTO)
			p = 8'd6;
		return p;
	endfunction

	function automatic logic [PORT_W-1:0] pick_port();
		case ($urandom_range(0, 5))
			0: return 16'd80;
			1: return 16'd443;
			2: return 16'd53;
			3: return 16'd0;
			4: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	// addresses drawn from a small pool so that keys collide often
	task automatic pick_addr(input logic v6, output logic [ADDR_W-1:0] hi,
	                         output logic [ADDR_W-1:0] lo);
		logic [31:0] v4;
		case ($urandom_range(0, 3))
			0: v4 = V4_A;
			1: v4 = V4_B;
			2: v4 = 32'h7f00_0001;
			default: v4 = $urandom;
		endcase
		if (!v6) begin
			// upper bits are don't-care for v4, fill them with junk at times
			hi = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'd0;
			lo = {($urandom_range(0, 1) ? $urandom : 32'd0),
			      ($urandom_range(0, 4) == 0 ? 32'd0 : v4)};
		end else begin
			case ($urandom_range(0, 5))
				0: begin hi = '0; lo = '0; end
				1, 2: begin hi = '0; lo = {MAPPED_TAG, v4}; end
				3: begin hi = {$urandom, $urandom}; lo = {$urandom, $urandom}; end
				4: begin hi = 64'd1; lo = {MAPPED_TAG, v4}; end  // not a mapped form
				default: begin hi = '0; lo = {32'h0000_fffe, v4}; end
			endcase
		end
	endtask

	function automatic logic [PID_W-1:0] pick_pid();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return 22'($urandom);
		endcase
	endfunction

	task automatic rand_insert(input bit drain);
		logic               v6;
		logic [ADDR_W-1:0]  hi;
		logic [ADDR_W-1:0]  lo;
		v6 = 1'($urandom_range(0, 1));
		pick_addr(v6, hi, lo);
		push_req(REQ_INSERT, v6, pick_proto(), pick_port(), hi, lo, pick_pid(), drain);
	endtask

	task automatic rand_lookup(input bit drain);
		entry_t             e;
		logic               v6;
		logic [PROTO_W-1:0] proto;
		logic [PORT_W-1:0]  prt;
		logic [ADDR_W-1:0]  hi;
		logic [ADDR_W-1:0]  lo;
		if (gen_live.size() != 0 && $urandom_range(0, 3) != 0) begin
			e     = gen_live[$urandom_range(0, gen_live.size() - 1)];
			v6    = e.is_ipv6;
			proto = e.protocol;
			prt   = e.port;
			hi    = e.addr_hi;
			lo    = e.addr_lo;
			case ($urandom_range(0, 4))
				0: ;                            // exact key and address
				1: pick_addr(v6, hi, lo);       // same key, other address
				2: begin
					if (v6 && hi == '0 && lo[63:32] == MAPPED_TAG) begin
						// v4 query for a mapped entry, junk in the ignored bits
						v6        = 1'b0;
						hi        = {$urandom, $urandom};
						lo[63:32] = $urandom;
					end else begin
						v6 = ~v6;
					end
				end
				3: begin hi = {$urandom, $urandom}; lo[63:32] = $urandom; end
				default: prt = prt + 16'd1;
			endcase
		end else begin
			v6    = 1'($urandom_range(0, 1));
			proto = 8'($urandom);
			prt   = 16'($urandom);
			pick_addr(v6, hi, lo);
		end
		push_req(REQ_LOOKUP, v6, proto, prt, hi, lo, pick_pid(), drain);
	endtask

	task automatic rand_noise(input bit drain);
		push_req(REQ_UNUSED, 1'($urandom_range(0, 1)), 8'($urandom), 16'($urandom),
		         {$urandom, $urandom}, {$urandom, $urandom}, 22'($urandom), drain);
	endtask

	// ------------------------------------------------------------------
	// Driver: request side, changes at the falling edge.
	// ------------------------------------------------------------------
	always @(negedge clk) begin : drive
		sock_req_t nx;
		// a pending transaction stays on the bus untouched until accepted
		if (arst_n && !(in_valid && !in_fire)) begin
			if (in_valid) begin
				send_gap = next_gap(send_burst);
				if ($urandom_range(0, 39) == 0)
					send_burst = ~send_burst;
			end
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (req_backlog.size() != 0 &&
			             !(req_backlog[0].drain && replies_due.size() != 0)) begin
				nx = req_backlog.pop_front();
				in_valid  <= 1'b1;
				req_type  <= nx.kind;
				is_ipv6   <= nx.v6;
				protocol  <= nx.proto;
				port      <= nx.port;
				addr_hi   <= nx.hi;
				addr_lo   <= nx.lo;
				owner_pid <= nx.pid;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: draws a back-off per reply, plus two long hold-offs that
	// back the block up until it stops taking requests.
	// ------------------------------------------------------------------
	always @(negedge clk) begin : receive
		if (arst_n) begin
			if (out_fire) begin
				if (results_seen == STALL_AT_A || results_seen == STALL_AT_B)
					recv_gap = STALL_LEN;
				else
					recv_gap = next_gap(recv_burst);
				if ($urandom_range(0, 39) == 0)
					recv_burst = ~recv_burst;
			end
			if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic check_field(input string what, input logic [31:0] want,
	                           input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
			mismatches++;
		end
	endtask

	// ------------------------------------------------------------------
	// Monitor: samples both channels at the rising edge, predicts each
	// accepted request and checks each accepted reply in order.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : watch
		sock_req_t    seen;
		owner_reply_t want;
		in_fire  <= in_valid && in_ready;
		out_fire <= out_valid && out_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (replies_due.size() == 0) begin
					$display("%0t: unexpected reply, expected none, actual found %0d pid %0h idx %0d drop %0d",
					         $time, found, match_pid, match_index, dropped);
					mismatches++;
				end else begin
					want = replies_due.pop_front();
					check_field("found", 32'(want.found), 32'(found));
					check_field("match_pid", 32'(want.pid), 32'(match_pid));
					check_field("match_index", 32'(want.index), 32'(match_index));
					check_field("dropped", 32'(want.dropped), 32'(dropped));
				end
			end
			if (in_valid && in_ready) begin
				seen = '{kind: req_type, v6: is_ipv6, proto: protocol, port: port,
				         hi: addr_hi, lo: addr_lo, pid: owner_pid, drain: 1'b0};
				replies_due.push_back(predict_reply(seen));
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d replies still due", $time, replies_due.size());
			$display("** socket_owner_lookup_table_core: FAILED **");
			$finish;
		end
	end

	initial begin : stimulus
		int random_start;
		int n_ins;
		int n_look;
		bit first_drain;

		// --- directed: empty table, wildcard order, mapped v4, families ---
		push_req(REQ_LOOKUP,  1'b0, 8'd6, 16'd80, '0, {32'd0, V4_A}, '0, 1'b0);
		push_req(REQ_PUBLISH, 1'b0, '0, '0, '0, '0, '0, 1'b0);        // publish of nothing
		push_req(REQ_INSERT,  1'b0, 8'd6, 16'd80, '0, '0, '1, 1'b0);  // v4 wildcard
		push_req(REQ_INSERT,  1'b0, 8'd6, 16'd80, '1, {32'hffff_ffff, V4_A}, '0, 1'b0);
		push_req(REQ_INSERT,  1'b1, 8'd17, 16'd53, '0, {MAPPED_TAG, V4_B}, 22'h000123, 1'b0);
		push_req(REQ_INSERT,  1'b1, 8'd17, 16'hffff, '0, '0, 22'h155555, 1'b0);
		push_req(REQ_INSERT,  1'b1, 8'hff, 16'd0, '1, '1, 22'h2aaaaa, 1'b0);
		push_req(REQ_INSERT,  1'b0, 8'd6, 16'd81, '0, {32'd0, V4_A}, 22'd7, 1'b0);
		// staging is not visible before a publish
		push_req(REQ_LOOKUP,  1'b0, 8'd6, 16'd80, '0, {32'd0, V4_A}, '0, 1'b0);
		push_req(REQ_PUBLISH, 1'b0, '0, '0, '0, '0, '0, 1'b1);
		push_req(REQ_LOOKUP,  1'b0, 8'd6, 16'd80, '1, {32'hdead_beef, V4_A}, '0, 1'b0);
		push_req(REQ_LOOKUP,  1'b0, 8'd6, 16'd81, '0, {32'h1234_5678, V4_A}, '0, 1'b0);
		push_req(REQ_LOOKUP,  1'b0, 8'd6, 16'd81, '0, {32'd0, V4_B}, '0, 1'b0);
		push_req(REQ_LOOKUP,  1'b0, 8'd17, 16'd53, '1, {32'h1234_5678, V4_B}, '0, 1'b0);
		push_req(REQ_LOOKUP,  1'b1, 8'd17, 16'd53, '0, {MAPPED_TAG, V4_B}, '0, 1'b0);
		push_req(REQ_LOOKUP,  1'b1, 8'd17, 16'd53, '0, {MAPPED_TAG, V4_A}, '0, 1'b0);
		push_req(REQ_LOOKUP,  1'b1, 8'd17, 16'hffff, 64'h2001_0db8_0000_0001, 64'd5, '0, 1'b0);
		push_req(REQ_LOOKUP,  1'b0, 8'd17, 16'hffff, '0, '0, '0, 1'b0);
		push_req(REQ_LOOKUP,  1'b1, 8'hff, 16'd0, '1, '1, '1, 1'b0);
		push_req(REQ_LOOKUP,  1'b1, 8'd6, 16'd80, '0, '0, '0, 1'b0);
		push_req(REQ_UNUSED,  1'b1, 8'hff, 16'hffff, '1, '1, '1, 1'b1);
		push_req(REQ_UNUSED,  1'b0, '0, '0, '0, '0, '0, 1'b0);

		random_start = queued_n;

		// --- fill staging to the brim, then overflow it ---
		for (int i = 0; i < TABLE_DEPTH - 1; i++)
			rand_insert(1'b0);
		push_req(REQ_INSERT, 1'b0, DEEP_PROTO, DEEP_PORT, '0, {32'd0, V4_A}, 22'h2aaaaa, 1'b0);
		rand_insert(1'b1);
		rand_insert(1'b0);
		rand_insert(1'b0);
		rand_lookup(1'b0);
		push_req(REQ_PUBLISH, 1'b0, '0, '0, '0, '0, '0, 1'b0);
		// hit on the last slot, and a miss that scans the whole bank
		push_req(REQ_LOOKUP, 1'b0, DEEP_PROTO, DEEP_PORT, '1, {32'd0, V4_A}, '0, 1'b0);
		push_req(REQ_LOOKUP, 1'b0, DEEP_PROTO, DEEP_PORT, '0, {32'd0, V4_B}, '0, 1'b0);
		for (int i = 0; i < 18; i++)
			rand_lookup(1'b0);

		// --- rounds: a small batch of inserts, publish, lookups, some noise ---
		while (queued_n < random_start + RANDOM_ITEMS) begin
			first_drain = $urandom_range(0, 5) == 0;
			n_ins = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
			for (int i = 0; i < n_ins; i++) begin
				case ($urandom_range(0, 11))
					0: rand_noise(first_drain && i == 0);
					1: rand_lookup(first_drain && i == 0);
					default: rand_insert(first_drain && i == 0);
				endcase
			end
			push_req(REQ_PUBLISH, 1'b0, '0, '0, '0, '0, '0, first_drain && n_ins == 0);
			n_look = $urandom_range(1, 15);
			for (int i = 0; i < n_look; i++) begin
				case ($urandom_range(0, 19))
					0: rand_noise(1'b0);
					1: rand_insert(1'b0);   // lands in staging for the next round
					default: rand_lookup(1'b0);
				endcase
			end
		end

		// release reset on a falling edge, away from the sampling edge
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (req_backlog.size() != 0 || in_valid)
			@(posedge clk);
		while (replies_due.size() != 0)
			@(posedge clk);
		// long enough for a full scan, in case a stray reply follows
		repeat (TABLE_DEPTH + 8) @(posedge clk);

		if (mismatches == 0)
			$display("** socket_owner_lookup_table_core: PASSED **");
		else
			$display("** socket_owner_lookup_table_core: FAILED **");
		$finish;
	end

endmodule
